>>> rtl/core/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants for the sliding window min/max block.
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

  // Default depth of the sample store and default sample width
  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Window length register
  localparam int                  CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd1;

endpackage : swmm_pkg

`default_nettype wire

>>> rtl/core/swmm_ram.sv
// ----------------------------------------------------------------------------
// swmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : swmm_ram

`default_nettype wire

>>> rtl/core/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Minimum and maximum over the last window_length samples of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one signed sample per request
//   plus a restart flag that begins a new sequence with that sample.
//   Output channel (out_valid / out_stall) carries window_min / window_max.
//   A sample produces a result once the current sequence holds at least
//   window_length samples; earlier samples produce nothing.
//   cfg_wr_en / cfg_wr_data write window_length (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX); write it only while the block is idle.
// Operation:
//   The store is one RAM with a registered read port. After a sample is
//   written, the older window_length-1 entries are read back one per cycle
//   and folded into running min/max registers. A sample that yields a
//   result keeps the block busy (in_stall high) through the scan and final
//   fold states (skipped for a window of one) and the completion state,
//   which loads the result into the output register and raises out_valid;
//   a sample that yields no result leaves the block idle.
// Reset and back-pressure:
//   Synchronous active-low reset clears fill count, write position, the
//   window length (to 1) and all control state; store contents stay
//   undefined and are never read before being written in a sequence.
//   The output register holds a result while out_stall is high; the block
//   still accepts a new request meanwhile and only waits when a second
//   result is ready before the first was taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input request channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                           in_restart_sequence,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed      [SAMPLE_WIDTH-1:0] out_window_min,
  output logic signed      [SAMPLE_WIDTH-1:0] out_window_max,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic        [CFG_WIDTH-1:0]    cfg_wr_data
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int LW = $clog2(WINDOW_MAX + 1);

  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_MAX - 1);
  localparam logic [LW-1:0] MAX_LEN   = LW'(WINDOW_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            wpos_r, wpos_nxt;
  logic [LW-1:0]            fill_r, fill_nxt;
  logic [CFG_WIDTH-1:0]     wlen_r, wlen_nxt;
  logic [AW-1:0]            rd_addr_r, rd_addr_nxt;
  logic [LW-1:0]            rem_r, rem_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic signed [SAMPLE_WIDTH-1:0] lo_r, lo_nxt;
  logic signed [SAMPLE_WIDTH-1:0] hi_r, hi_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_min_r, out_min_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_max_r, out_max_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic signed [SAMPLE_WIDTH-1:0] ram_rdata;

  logic [LW-1:0]            len_eff;
  logic [AW-1:0]            pos;
  logic [LW-1:0]            fill_new;
  logic signed [SAMPLE_WIDTH-1:0] lo_fold, hi_fold;

  swmm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_sample),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Clamp the configured length into 1..WINDOW_MAX
  always_comb begin
    if (wlen_r == '0) begin
      len_eff = LW'(1);
    end else if (int'(wlen_r) > WINDOW_MAX) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = LW'(wlen_r);
    end
  end

  // A restart puts the sample in slot zero and makes it the first of the sequence
  assign pos      = in_restart_sequence ? '0 : wpos_r;
  assign fill_new = in_restart_sequence ? LW'(1)
                  : ((fill_r < MAX_LEN) ? fill_r + LW'(1) : fill_r);

  // Fold the word coming back from the store into the running extremes
  assign lo_fold = (ram_rdata < lo_r) ? ram_rdata : lo_r;
  assign hi_fold = (ram_rdata > hi_r) ? ram_rdata : hi_r;

  always_comb begin
    state_nxt     = state_r;
    wpos_nxt      = wpos_r;
    fill_nxt      = fill_r;
    wlen_nxt      = wlen_r;
    rd_addr_nxt   = rd_addr_r;
    rem_nxt       = rem_r;
    rd_vld_nxt    = rd_vld_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    ram_we        = 1'b0;
    ram_waddr     = pos;

    if (cfg_wr_en) begin
      wlen_nxt = cfg_wr_data;
    end

    // Drop the held result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Store the sample and advance the write position
          ram_we      = 1'b1;
          wpos_nxt    = (pos == LAST_ADDR) ? '0 : pos + AW'(1);
          fill_nxt    = fill_new;
          lo_nxt      = in_sample;
          hi_nxt      = in_sample;
          rd_addr_nxt = (pos == '0) ? LAST_ADDR : pos - AW'(1);
          rem_nxt     = len_eff - LW'(1);
          rd_vld_nxt  = 1'b0;
          if (fill_new >= len_eff) begin
            state_nxt = (len_eff == LW'(1)) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle, walking back through older entries
        rd_addr_nxt = (rd_addr_r == '0) ? LAST_ADDR : rd_addr_r - AW'(1);
        rem_nxt     = rem_r - LW'(1);
        rd_vld_nxt  = 1'b1;
        if (rd_vld_r) begin
          lo_nxt = lo_fold;
          hi_nxt = hi_fold;
        end
        if (rem_r == LW'(1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        // Fold the final read
        lo_nxt     = lo_fold;
        hi_nxt     = hi_fold;
        rd_vld_nxt = 1'b0;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = lo_r;
          out_max_nxt   = hi_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wpos_r      <= '0;
      fill_r      <= '0;
      wlen_r      <= CFG_RESET;
      rem_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wpos_r      <= wpos_nxt;
      fill_r      <= fill_nxt;
      wlen_r      <= wlen_nxt;
      rem_r       <= rem_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r <= rd_addr_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;
  assign out_window_max = out_max_r;

  // A new result only ever comes from the completion state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside completion state");

  // The scan never runs with no reads left to issue
  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rem_r != '0))
    else $error("scan state with zero remaining reads");

  // The final fold always sees valid read data
  a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAST) |-> rd_vld_r)
    else $error("final fold without read data");

  // Fill count saturates at the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= WINDOW_MAX)
    else $error("fill count beyond store depth");

  // An unaccepted result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_min_r) && $stable(out_max_r)))
    else $error("pending result overwritten");

endmodule : sliding_window_min_max

`default_nettype wire
